### sv/tlpt_pkg.sv
package tlpt_pkg;

    localparam int DIR_ENTRIES_DEF   = 1024;
    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int PAGE_BYTES        = 4096;

    localparam int ADDR_W    = 32;
    localparam int IDX_W     = 10;
    localparam int OFFSET_W  = $clog2(PAGE_BYTES);
    localparam int DIR_SHIFT = 22;
    localparam int TBL_SHIFT = 12;
    localparam int FRAME_W   = ADDR_W - OFFSET_W;
    localparam int FLAGS_W   = 8;
    localparam int DIR_W     = 9;
    localparam int PTE_W     = FRAME_W + FLAGS_W;
    localparam int COUNT_W   = 11;
    localparam int STATUS_W  = 3;
    localparam int CMD_W     = 2;

    localparam logic [CMD_W-1:0] CMD_TRANSLATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MAP       = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNMAP     = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_ALIGN    = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOMEM    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_DUP      = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_UNMAPPED = 3'd4;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] ADDR_MAX_TABLES = 3'd0;
    localparam logic [COUNT_W-1:0] MAX_TABLES_RESET = 11'd1024;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [ADDR_W-1:0]  virt_addr;
        logic [ADDR_W-1:0]  phys_addr;
        logic [FLAGS_W-1:0] entry_flags;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   phys_result;
        logic [COUNT_W-1:0]  tables_in_use;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PAGE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic page_rd;
        logic exec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
    } ctrl_stat_t;

endpackage

### sv/tlpt_regs.sv
module tlpt_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tlpt_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [tlpt_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [tlpt_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [tlpt_pkg::COUNT_W-1:0]        max_tables
);

    logic [tlpt_pkg::COUNT_W-1:0] max_tables_reg;
    logic [tlpt_pkg::COUNT_W-1:0] max_tables_next;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        max_tables_next = max_tables_reg;
        if (wr_en && (paddr == tlpt_pkg::ADDR_MAX_TABLES))
        begin
            max_tables_next = pwdata[tlpt_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_tables_reg <= tlpt_pkg::MAX_TABLES_RESET;
        end
        else
        begin
            max_tables_reg <= max_tables_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == tlpt_pkg::ADDR_MAX_TABLES)
        begin
            prdata = {{(tlpt_pkg::CFG_DATA_W - tlpt_pkg::COUNT_W){1'b0}}, max_tables_reg};
        end
    end

    assign max_tables = max_tables_reg;

endmodule

### sv/tlpt_ctrl.sv
module tlpt_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  tlpt_pkg::ctrl_stat_t   stat,
    output tlpt_pkg::ctrl_cmd_t    cmd,
    output logic                   busy
);

    tlpt_pkg::state_t state_reg;
    tlpt_pkg::state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tlpt_pkg::ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = tlpt_pkg::ST_IDLE;
                end
            end
            tlpt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = tlpt_pkg::ST_PAGE;
                end
            end
            tlpt_pkg::ST_PAGE:
            begin
                state_next = tlpt_pkg::ST_EXEC;
            end
            tlpt_pkg::ST_EXEC:
            begin
                state_next = tlpt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tlpt_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlpt_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            tlpt_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            tlpt_pkg::ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            tlpt_pkg::ST_PAGE:
            begin
                cmd.page_rd = 1'b1;
            end
            tlpt_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

### sv/tlpt_datapath.sv
module tlpt_datapath #(
    parameter int DIR_ENTRIES   = tlpt_pkg::DIR_ENTRIES_DEF,
    parameter int TABLE_ENTRIES = tlpt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tlpt_pkg::ctrl_cmd_t             cmd,
    output tlpt_pkg::ctrl_stat_t            stat,
    input  tlpt_pkg::req_t                  request,
    input  logic [tlpt_pkg::COUNT_W-1:0]    max_tables,
    output logic                            done,
    output tlpt_pkg::rsp_t                  result
);

    localparam int DIR_IW     = $clog2(DIR_ENTRIES);
    localparam int TBL_IW     = $clog2(TABLE_ENTRIES);
    localparam int PAGE_DEPTH = DIR_ENTRIES * TABLE_ENTRIES;
    localparam int SLOT_W     = $clog2(PAGE_DEPTH);
    localparam logic [tlpt_pkg::IDX_W:0] DIR_LIMIT = (tlpt_pkg::IDX_W + 1)'(DIR_ENTRIES);
    localparam logic [tlpt_pkg::IDX_W:0] TBL_LIMIT = (tlpt_pkg::IDX_W + 1)'(TABLE_ENTRIES);
    localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(PAGE_DEPTH - 1);
    localparam logic [SLOT_W-1:0] DIR_CLR_END = SLOT_W'(DIR_ENTRIES);
    localparam logic [SLOT_W-1:0] TBL_STRIDE = SLOT_W'(TABLE_ENTRIES);

    logic [tlpt_pkg::DIR_W-1:0]   dir_mem  [DIR_ENTRIES];
    logic [tlpt_pkg::COUNT_W-1:0] live_mem [DIR_ENTRIES];
    logic [tlpt_pkg::PTE_W-1:0]   page_mem [PAGE_DEPTH];

    tlpt_pkg::req_t               req_reg;
    logic                         range_ok_reg;
    logic [DIR_IW-1:0]            d_idx_reg;
    logic [TBL_IW-1:0]            t_idx_reg;
    logic [SLOT_W-1:0]            slot_reg;
    logic [tlpt_pkg::DIR_W-1:0]   dir_rd_reg;
    logic [tlpt_pkg::COUNT_W-1:0] live_rd_reg;
    logic [tlpt_pkg::PTE_W-1:0]   page_rd_reg;
    logic [tlpt_pkg::COUNT_W-1:0] tc_reg;
    logic [tlpt_pkg::COUNT_W-1:0] tc_next;
    logic [SLOT_W-1:0]            clr_cnt_reg;
    logic                         done_reg;
    tlpt_pkg::rsp_t               result_reg;

    logic [tlpt_pkg::IDX_W-1:0]   d_in;
    logic [tlpt_pkg::IDX_W-1:0]   t_in;
    logic                         d_in_ok;
    logic                         t_in_ok;
    logic [DIR_IW-1:0]            d_in_idx;
    logic [TBL_IW-1:0]            t_in_idx;
    logic [SLOT_W-1:0]            slot;

    logic                         x_dir_we;
    logic [tlpt_pkg::DIR_W-1:0]   x_dir_wd;
    logic                         x_live_we;
    logic [tlpt_pkg::COUNT_W-1:0] x_live_wd;
    logic                         x_page_we;
    logic [tlpt_pkg::PTE_W-1:0]   x_page_wd;
    logic [tlpt_pkg::STATUS_W-1:0] x_status;
    logic [tlpt_pkg::ADDR_W-1:0]  x_phys;
    logic [tlpt_pkg::COUNT_W-1:0] live_base;
    logic [tlpt_pkg::COUNT_W-1:0] live_dec;
    logic                         misaligned;
    logic                         clr_dir;

    logic                         dir_we;
    logic [DIR_IW-1:0]            dir_wa;
    logic                         page_we;
    logic [SLOT_W-1:0]            page_wa;

    // index split straight off the request port, read at accept
    assign d_in     = request.virt_addr[tlpt_pkg::DIR_SHIFT +: tlpt_pkg::IDX_W];
    assign t_in     = request.virt_addr[tlpt_pkg::TBL_SHIFT +: tlpt_pkg::IDX_W];
    assign d_in_ok  = {1'b0, d_in} < DIR_LIMIT;
    assign t_in_ok  = {1'b0, t_in} < TBL_LIMIT;
    assign d_in_idx = d_in_ok ? d_in[DIR_IW-1:0] : '0;
    assign t_in_idx = t_in_ok ? t_in[TBL_IW-1:0] : '0;

    assign slot = SLOT_W'(SLOT_W'(d_idx_reg) * TBL_STRIDE) + SLOT_W'(t_idx_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg      <= request;
            range_ok_reg <= d_in_ok && t_in_ok;
            d_idx_reg    <= d_in_idx;
            t_idx_reg    <= t_in_idx;
        end
        if (cmd.page_rd)
        begin
            slot_reg <= slot;
        end
    end

    assign misaligned = (req_reg.virt_addr[tlpt_pkg::OFFSET_W-1:0] != '0)
                     || (req_reg.phys_addr[tlpt_pkg::OFFSET_W-1:0] != '0);

    always_comb
    begin
        x_status  = tlpt_pkg::STATUS_UNMAPPED;
        x_phys    = '0;
        tc_next   = tc_reg;
        x_dir_we  = 1'b0;
        x_dir_wd  = '0;
        x_live_we = 1'b0;
        x_live_wd = live_rd_reg;
        x_page_we = 1'b0;
        x_page_wd = '0;
        live_base = live_rd_reg;
        live_dec  = (live_rd_reg != '0) ? live_rd_reg - 1'b1 : '0;
        unique case (req_reg.command)
            tlpt_pkg::CMD_TRANSLATE:
            begin
                if (range_ok_reg && dir_rd_reg[0] && page_rd_reg[0])
                begin
                    x_status = tlpt_pkg::STATUS_OK;
                    x_phys   = {page_rd_reg[tlpt_pkg::PTE_W-1:tlpt_pkg::FLAGS_W],
                                req_reg.virt_addr[tlpt_pkg::OFFSET_W-1:0]};
                end
            end
            tlpt_pkg::CMD_MAP:
            begin
                if (misaligned)
                begin
                    x_status = tlpt_pkg::STATUS_ALIGN;
                end
                else if (!range_ok_reg)
                begin
                    x_status = tlpt_pkg::STATUS_NOMEM;
                end
                else if (!dir_rd_reg[0] && (tc_reg >= max_tables))
                begin
                    x_status = tlpt_pkg::STATUS_NOMEM;
                end
                else
                begin
                    if (!dir_rd_reg[0])
                    begin
                        // new table: directory entry always marked present
                        x_dir_we  = 1'b1;
                        x_dir_wd  = {1'b0, req_reg.entry_flags | 8'h01};
                        tc_next   = tc_reg + 1'b1;
                        live_base = '0;
                        x_live_we = 1'b1;
                        x_live_wd = '0;
                    end
                    if (page_rd_reg[0])
                    begin
                        x_status = tlpt_pkg::STATUS_DUP;
                    end
                    else
                    begin
                        x_status  = tlpt_pkg::STATUS_OK;
                        x_page_we = 1'b1;
                        x_page_wd = {req_reg.phys_addr[tlpt_pkg::ADDR_W-1:tlpt_pkg::OFFSET_W],
                                     req_reg.entry_flags};
                        x_live_we = 1'b1;
                        x_live_wd = live_base
                                  + {{(tlpt_pkg::COUNT_W - 1){1'b0}}, req_reg.entry_flags[0]};
                    end
                end
            end
            tlpt_pkg::CMD_UNMAP:
            begin
                if (range_ok_reg && dir_rd_reg[0] && page_rd_reg[0])
                begin
                    x_status  = tlpt_pkg::STATUS_OK;
                    x_page_we = 1'b1;
                    x_page_wd = '0;
                    x_live_we = 1'b1;
                    x_live_wd = live_dec;
                    // last present entry gone: table freed, stale entries are all not present
                    if (live_dec == '0)
                    begin
                        x_dir_we = 1'b1;
                        x_dir_wd = '0;
                        tc_next  = (tc_reg != '0) ? tc_reg - 1'b1 : tc_reg;
                    end
                end
            end
            default:
            begin
                x_status = tlpt_pkg::STATUS_UNMAPPED;
            end
        endcase
    end

    assign clr_dir = cmd.clear && (clr_cnt_reg < DIR_CLR_END);
    assign dir_we  = clr_dir || (cmd.exec && (x_dir_we || x_live_we));
    assign dir_wa  = cmd.clear ? clr_cnt_reg[DIR_IW-1:0] : d_idx_reg;
    assign page_we = cmd.clear || (cmd.exec && x_page_we);
    assign page_wa = cmd.clear ? clr_cnt_reg : slot_reg;

    always_ff @(posedge clk)
    begin
        if (clr_dir)
        begin
            dir_mem[dir_wa]  <= '0;
            live_mem[dir_wa] <= '0;
        end
        else if (dir_we)
        begin
            if (x_dir_we)
            begin
                dir_mem[dir_wa] <= x_dir_wd;
            end
            if (x_live_we)
            begin
                live_mem[dir_wa] <= x_live_wd;
            end
        end
        if (cmd.capture)
        begin
            dir_rd_reg  <= dir_mem[d_in_idx];
            live_rd_reg <= live_mem[d_in_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (page_we)
        begin
            page_mem[page_wa] <= cmd.clear ? '0 : x_page_wd;
        end
        if (cmd.page_rd)
        begin
            page_rd_reg <= page_mem[slot];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg      <= '0;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.exec;
            if (cmd.exec)
            begin
                tc_reg <= tc_next;
            end
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            result_reg.status        <= x_status;
            result_reg.phys_result   <= x_phys;
            result_reg.tables_in_use <= tc_next;
        end
    end

    assign stat.clear_last = clr_cnt_reg == SLOT_LAST;
    assign done            = done_reg;
    assign result          = result_reg;

endmodule

### sv/two_level_page_table_engine.sv
// Two-level page table engine. A request is taken at a clock edge with start high and busy
// low; it reads the directory entry and live count in the accept cycle, the page entry in
// the PAGE state that follows, then decides and writes back in the EXEC state. Its result is
// shown for one cycle with done high, and the result must be taken then: there is no way to
// hold it off. Busy stays high in PAGE and EXEC, so no new request is taken until the last
// one has been decided. After reset the page table memory is swept to zero with busy high;
// max_tables can be written over the APB port throughout.
module two_level_page_table_engine #(
    parameter int DIR_ENTRIES   = tlpt_pkg::DIR_ENTRIES_DEF,
    parameter int TABLE_ENTRIES = tlpt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  tlpt_pkg::req_t                    request,
    output logic                              busy,
    output logic                              done,
    output tlpt_pkg::rsp_t                    result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tlpt_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [tlpt_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [tlpt_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);

    tlpt_pkg::ctrl_cmd_t          cmd;
    tlpt_pkg::ctrl_stat_t         stat;
    logic [tlpt_pkg::COUNT_W-1:0] max_tables;

    tlpt_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .max_tables (max_tables)
    );

    tlpt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tlpt_datapath #(
        .DIR_ENTRIES   (DIR_ENTRIES),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .request    (request),
        .max_tables (max_tables),
        .done       (done),
        .result     (result)
    );

endmodule

### verif/two_level_page_table_engine_tb.sv
`timescale 1ns / 100ps

module two_level_page_table_engine_tb;

    localparam int          CYCLE_LIMIT     = 4_000_000;
    localparam int          ITEMS_PER_PHASE = 135;
    localparam int          NUM_PHASES      = 7;
    localparam int          POOL_SIZE       = 6;
    localparam logic [tlpt_pkg::CMD_W-1:0] CMD_RESERVED = 2'd3;

    typedef struct {
        tlpt_pkg::req_t req;
        bit             typed;
        tlpt_pkg::rsp_t want;
    } script_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    tlpt_pkg::req_t                  request;
    logic                            busy;
    logic                            done;
    tlpt_pkg::rsp_t                  result;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [tlpt_pkg::CFG_ADDR_W-1:0] paddr;
    logic [tlpt_pkg::CFG_DATA_W-1:0] pwdata;
    logic [tlpt_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    // shadow of the walk state
    logic [tlpt_pkg::DIR_W-1:0]   dir_tab [tlpt_pkg::DIR_ENTRIES_DEF];
    logic [tlpt_pkg::COUNT_W-1:0] live_cnt [tlpt_pkg::DIR_ENTRIES_DEF];
    logic [tlpt_pkg::PTE_W-1:0]   pte_store [int unsigned];
    logic [tlpt_pkg::COUNT_W-1:0] table_total;
    logic [tlpt_pkg::COUNT_W-1:0] table_limit;

    tlpt_pkg::rsp_t walk_results_due [$];
    script_row_t    walk_script [$];
    int unsigned    dir_pool [POOL_SIZE];
    int unsigned    tbl_pool [POOL_SIZE];

    int          fail_count;
    int          beats_sent;
    int          beats_checked;
    int          status_seen [5];
    int unsigned cycle_count;
    bit          steady;

    two_level_page_table_engine u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, walk_results_due.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [tlpt_pkg::PTE_W-1:0] pte_read(int unsigned slot);
        return pte_store.exists(slot) ? pte_store[slot] : '0;
    endfunction

    // updates the shadow tables and returns the result the block should give
    function automatic tlpt_pkg::rsp_t predict_walk(tlpt_pkg::req_t r);
        tlpt_pkg::rsp_t             o;
        int unsigned                d;
        int unsigned                t;
        int unsigned                slot;
        int unsigned                key;
        logic [tlpt_pkg::PTE_W-1:0] pe;
        d = r.virt_addr[tlpt_pkg::ADDR_W-1:tlpt_pkg::DIR_SHIFT];
        t = r.virt_addr[tlpt_pkg::DIR_SHIFT-1:tlpt_pkg::TBL_SHIFT];
        slot = d * tlpt_pkg::TABLE_ENTRIES_DEF + t;
        o.status = tlpt_pkg::STATUS_UNMAPPED;
        o.phys_result = '0;
        case (r.command)
            tlpt_pkg::CMD_TRANSLATE:
            begin
                pe = pte_read(slot);
                if (dir_tab[d][0] && pe[0])
                begin
                    o.status = tlpt_pkg::STATUS_OK;
                    o.phys_result = {pe[tlpt_pkg::PTE_W-1:tlpt_pkg::FLAGS_W],
                                     r.virt_addr[tlpt_pkg::OFFSET_W-1:0]};
                end
            end
            tlpt_pkg::CMD_MAP:
            begin
                if (r.virt_addr[tlpt_pkg::OFFSET_W-1:0] != '0
                    || r.phys_addr[tlpt_pkg::OFFSET_W-1:0] != '0)
                    o.status = tlpt_pkg::STATUS_ALIGN;
                else if (!dir_tab[d][0] && table_total >= table_limit)
                    o.status = tlpt_pkg::STATUS_NOMEM;
                else
                begin
                    if (!dir_tab[d][0])
                    begin
                        dir_tab[d] = {1'b0, r.entry_flags | 8'h01};
                        live_cnt[d] = '0;
                        table_total = table_total + 1'b1;
                    end
                    pe = pte_read(slot);
                    if (pe[0])
                        o.status = tlpt_pkg::STATUS_DUP;
                    else
                    begin
                        pte_store[slot] = {r.phys_addr[tlpt_pkg::ADDR_W-1:tlpt_pkg::OFFSET_W],
                                           r.entry_flags};
                        if (r.entry_flags[0])
                            live_cnt[d] = live_cnt[d] + 1'b1;
                        o.status = tlpt_pkg::STATUS_OK;
                    end
                end
            end
            tlpt_pkg::CMD_UNMAP:
            begin
                pe = pte_read(slot);
                if (dir_tab[d][0] && pe[0])
                begin
                    pte_store.delete(slot);
                    if (live_cnt[d] > 0)
                        live_cnt[d] = live_cnt[d] - 1'b1;
                    // last live page gone: the whole table goes with it
                    if (live_cnt[d] == 0)
                    begin
                        for (int k = 0; k < tlpt_pkg::TABLE_ENTRIES_DEF; k++)
                        begin
                            key = d * tlpt_pkg::TABLE_ENTRIES_DEF + k;
                            if (pte_store.exists(key))
                                pte_store.delete(key);
                        end
                        dir_tab[d] = '0;
                        if (table_total > 0)
                            table_total = table_total - 1'b1;
                    end
                    o.status = tlpt_pkg::STATUS_OK;
                end
            end
            default:
                o.status = tlpt_pkg::STATUS_UNMAPPED;
        endcase
        o.tables_in_use = table_total;
        return o;
    endfunction

    function automatic void add_row(logic [tlpt_pkg::CMD_W-1:0] cmd,
                                    logic [tlpt_pkg::ADDR_W-1:0] va,
                                    logic [tlpt_pkg::ADDR_W-1:0] pa,
                                    logic [tlpt_pkg::FLAGS_W-1:0] fl,
                                    bit typed, logic [tlpt_pkg::STATUS_W-1:0] st,
                                    logic [tlpt_pkg::ADDR_W-1:0] ph,
                                    logic [tlpt_pkg::COUNT_W-1:0] tiu);
        script_row_t row;
        row.req = '{command: cmd, virt_addr: va, phys_addr: pa, entry_flags: fl};
        row.typed = typed;
        row.want = '{status: st, phys_result: ph, tables_in_use: tiu};
        walk_script.push_back(row);
    endfunction

    function automatic tlpt_pkg::req_t make_random_req();
        tlpt_pkg::req_t r;
        int unsigned    pick;
        int unsigned    d;
        int unsigned    t;
        pick = $urandom_range(99);
        d = dir_pool[$urandom_range(POOL_SIZE-1)];
        t = tbl_pool[$urandom_range(POOL_SIZE-1)];
        r.virt_addr = {d[tlpt_pkg::IDX_W-1:0], t[tlpt_pkg::IDX_W-1:0], 12'h000};
        r.phys_addr = $urandom & 32'hFFFF_F000;
        r.entry_flags = $urandom_range(255);
        if (pick < 42)
        begin
            r.command = tlpt_pkg::CMD_MAP;
            r.entry_flags[0] = ($urandom_range(99) < 85);
            if ($urandom_range(99) < 6)
                r.virt_addr[tlpt_pkg::OFFSET_W-1:0] = $urandom_range(4095);
            if ($urandom_range(99) < 6)
                r.phys_addr[tlpt_pkg::OFFSET_W-1:0] = $urandom_range(4095);
        end
        else if (pick < 72)
        begin
            r.command = tlpt_pkg::CMD_TRANSLATE;
            r.virt_addr[tlpt_pkg::OFFSET_W-1:0] = $urandom_range(4095);
        end
        else if (pick < 95)
        begin
            r.command = tlpt_pkg::CMD_UNMAP;
            r.virt_addr[tlpt_pkg::OFFSET_W-1:0] = $urandom_range(4095);
        end
        else
        begin
            r.command = CMD_RESERVED;
            r.phys_addr = $urandom;
        end
        // stray addresses well away from the working set
        if ($urandom_range(99) < 3)
            r.virt_addr = $urandom;
        return r;
    endfunction

    // entered and left just after a falling edge; start is left high on return
    task automatic issue(tlpt_pkg::req_t r, bit typed, tlpt_pkg::rsp_t want);
        tlpt_pkg::rsp_t predicted;
        if (!steady)
        begin
            while ($urandom_range(99) < 8)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predicted = predict_walk(r);
        walk_results_due.push_back(typed ? want : predicted);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic apb_xfer(bit wr, logic [tlpt_pkg::CFG_DATA_W-1:0] wdata,
                            output logic [tlpt_pkg::CFG_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= tlpt_pkg::ADDR_MAX_TABLES;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_limit_reg(logic [tlpt_pkg::COUNT_W-1:0] want);
        logic [tlpt_pkg::CFG_DATA_W-1:0] rd;
        apb_xfer(1'b0, '0, rd);
        if (rd[tlpt_pkg::COUNT_W-1:0] !== want)
        begin
            $error("max_tables readback: expected %0d, got %0d",
                   want, rd[tlpt_pkg::COUNT_W-1:0]);
            fail_count++;
        end
    endtask

    task automatic set_limit(logic [tlpt_pkg::COUNT_W-1:0] value);
        logic [tlpt_pkg::CFG_DATA_W-1:0] rd;
        apb_xfer(1'b1, tlpt_pkg::CFG_DATA_W'(value), rd);
        table_limit = value;
        check_limit_reg(value);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        wait (walk_results_due.size() == 0);
        repeat (4) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        tlpt_pkg::rsp_t want;
        if (rst_n && done === 1'b1)
        begin
            if (walk_results_due.size() == 0)
            begin
                $error("result beat with nothing outstanding: status %0d", result.status);
                fail_count++;
            end
            else
            begin
                want = walk_results_due.pop_front();
                beats_checked++;
                if (result.status <= tlpt_pkg::STATUS_UNMAPPED)
                    status_seen[result.status]++;
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    fail_count++;
                end
                if (result.phys_result !== want.phys_result)
                begin
                    $error("phys_result: expected %08h, got %08h",
                           want.phys_result, result.phys_result);
                    fail_count++;
                end
                if (result.tables_in_use !== want.tables_in_use)
                begin
                    $error("tables_in_use: expected %0d, got %0d",
                           want.tables_in_use, result.tables_in_use);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        logic [tlpt_pkg::COUNT_W-1:0] limit_plan [NUM_PHASES];
        clk     = 1'b0;
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        fail_count = 0;
        beats_sent = 0;
        beats_checked = 0;
        cycle_count = 0;
        steady = 1'b0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        foreach (dir_tab[i])
        begin
            dir_tab[i] = '0;
            live_cnt[i] = '0;
        end
        table_total = '0;
        table_limit = tlpt_pkg::MAX_TABLES_RESET;
        limit_plan = '{11'd1024, 11'd0, 11'd1, 11'd3, 11'd1024, 11'd2, 11'd7};

        // directed walk, run with room for two tables
        add_row(tlpt_pkg::CMD_TRANSLATE, 32'h0000_0000, 32'h0, 8'h00,
                1, tlpt_pkg::STATUS_UNMAPPED, 0, 0);
        add_row(tlpt_pkg::CMD_UNMAP,     32'hFFFF_F000, 32'h0, 8'h00,
                1, tlpt_pkg::STATUS_UNMAPPED, 0, 0);
        add_row(CMD_RESERVED,            32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                1, tlpt_pkg::STATUS_UNMAPPED, 0, 0);
        add_row(tlpt_pkg::CMD_MAP,       32'h0000_0001, 32'h0, 8'h01,
                1, tlpt_pkg::STATUS_ALIGN, 0, 0);
        add_row(tlpt_pkg::CMD_MAP,       32'h0000_0000, 32'h0000_0800, 8'h01,
                1, tlpt_pkg::STATUS_ALIGN, 0, 0);
        add_row(tlpt_pkg::CMD_MAP,       32'hFFFF_F000, 32'hFFFF_F000, 8'hFF,
                1, tlpt_pkg::STATUS_OK, 0, 1);
        add_row(tlpt_pkg::CMD_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 8'h00,
                1, tlpt_pkg::STATUS_OK, 32'hFFFF_FFFF, 1);
        add_row(tlpt_pkg::CMD_MAP,       32'hFFFF_F000, 32'h0000_0000, 8'h01,
                1, tlpt_pkg::STATUS_DUP, 0, 1);
        // entry written without its present bit: the table still counts
        add_row(tlpt_pkg::CMD_MAP,       32'h0000_0000, 32'h0000_0000, 8'h00,
                1, tlpt_pkg::STATUS_OK, 0, 2);
        add_row(tlpt_pkg::CMD_TRANSLATE, 32'h0000_0ABC, 32'h0, 8'h00,
                1, tlpt_pkg::STATUS_UNMAPPED, 0, 2);
        add_row(tlpt_pkg::CMD_MAP,       32'h0040_0000, 32'h1234_5000, 8'h01,
                1, tlpt_pkg::STATUS_NOMEM, 0, 2);
        add_row(tlpt_pkg::CMD_UNMAP,     32'h0000_0000, 32'h0, 8'h00,
                1, tlpt_pkg::STATUS_UNMAPPED, 0, 2);
        add_row(tlpt_pkg::CMD_MAP,       32'h0000_0000, 32'hABCD_E000, 8'h03, 0, '0, 0, 0);
        add_row(tlpt_pkg::CMD_TRANSLATE, 32'h0000_0FFF, 32'h0, 8'h00, 0, '0, 0, 0);
        add_row(tlpt_pkg::CMD_MAP,       32'h003F_F000, 32'h0000_1000, 8'h81, 0, '0, 0, 0);
        add_row(tlpt_pkg::CMD_UNMAP,     32'h0000_0000, 32'h0, 8'h00, 0, '0, 0, 0);
        add_row(tlpt_pkg::CMD_UNMAP,     32'h003F_F000, 32'h0, 8'h00, 0, '0, 0, 0);
        add_row(tlpt_pkg::CMD_TRANSLATE, 32'h003F_F123, 32'h0, 8'h00, 0, '0, 0, 0);
        add_row(tlpt_pkg::CMD_MAP,       32'h0040_0000, 32'h1234_5000, 8'h01, 0, '0, 0, 0);
        add_row(tlpt_pkg::CMD_UNMAP,     32'hFFFF_F000, 32'h0, 8'h00, 0, '0, 0, 0);
        add_row(tlpt_pkg::CMD_TRANSLATE, 32'hFFFF_F000, 32'h0, 8'h00, 0, '0, 0, 0);
        add_row(tlpt_pkg::CMD_UNMAP,     32'h0040_0FFF, 32'h0, 8'h00, 0, '0, 0, 0);
        add_row(tlpt_pkg::CMD_MAP,       32'h8000_0000, 32'h8000_0000, 8'hFE, 0, '0, 0, 0);
        add_row(tlpt_pkg::CMD_TRANSLATE, 32'h8000_0000, 32'h0, 8'h00, 0, '0, 0, 0);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // the register is reachable while the memory sweep runs
        check_limit_reg(tlpt_pkg::MAX_TABLES_RESET);
        set_limit(11'd2);
        foreach (walk_script[i])
            issue(walk_script[i].req, walk_script[i].typed, walk_script[i].want);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            set_limit(limit_plan[ph]);
            // odd phases revisit the tables built in the phase before
            if (ph % 2 == 0)
            begin
                dir_pool[0] = 0;
                dir_pool[1] = tlpt_pkg::DIR_ENTRIES_DEF - 1;
                tbl_pool[0] = 0;
                tbl_pool[1] = tlpt_pkg::TABLE_ENTRIES_DEF - 1;
                for (int k = 2; k < POOL_SIZE; k++)
                begin
                    dir_pool[k] = $urandom_range(tlpt_pkg::DIR_ENTRIES_DEF - 1);
                    tbl_pool[k] = $urandom_range(tlpt_pkg::TABLE_ENTRIES_DEF - 1);
                end
            end
            steady = (ph == 4);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                issue(make_random_req(), 1'b0, '0);
        end

        start <= 1'b0;
        wait (walk_results_due.size() == 0);
        repeat (10) @(posedge clk);

        $display("walk requests sent %0d, result beats checked %0d, over %0d limit settings",
                 beats_sent, beats_checked, NUM_PHASES + 1);
        $display("status mix: ok %0d, align %0d, nomem %0d, dup %0d, unmapped %0d",
                 status_seen[tlpt_pkg::STATUS_OK], status_seen[tlpt_pkg::STATUS_ALIGN],
                 status_seen[tlpt_pkg::STATUS_NOMEM], status_seen[tlpt_pkg::STATUS_DUP],
                 status_seen[tlpt_pkg::STATUS_UNMAPPED]);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
